/* rtl/core/tlc_pkg.sv */
// tlc_pkg: shared types and constants for the two-level cache tag controller
// holds store geometry, line and row layouts, access and result structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

    localparam int L1_WAYS     = 4;
    localparam int L1_SETS     = 64;
    localparam int L2_WAYS     = 8;
    localparam int L2_SETS     = 256;
    localparam int VIC_ENTRIES = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_BLOCK_BITS  = 3'd0;
    localparam logic [2:0] CFG_L1_SET_BITS = 3'd1;
    localparam logic [2:0] CFG_L1_WAY_BITS = 3'd2;
    localparam logic [2:0] CFG_L2_SET_BITS = 3'd3;
    localparam logic [2:0] CFG_L2_WAY_BITS = 3'd4;
    localparam logic [2:0] CFG_WRITE_ALLOC = 3'd5;
    localparam logic [2:0] CFG_VICTIM_EN   = 3'd6;

    // level that served the access
    localparam logic [1:0] LVL_L1  = 2'd0;
    localparam logic [1:0] LVL_L2  = 2'd1;
    localparam logic [1:0] LVL_VIC = 2'd2;
    localparam logic [1:0] LVL_MEM = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [1:0]  rank;
        logic [31:0] blk;
    } t_l1_line;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [2:0]  rank;
        logic [31:0] blk;
    } t_l2_line;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [1:0]  rank;
        logic [31:0] blk;
    } t_vc_line;

    typedef t_l1_line [L1_WAYS-1:0]     t_l1_row;
    typedef t_l2_line [L2_WAYS-1:0]     t_l2_row;
    typedef t_vc_line [VIC_ENTRIES-1:0] t_vc_row;

    typedef struct packed {
        logic [31:0] byte_address;
        logic        is_write;
    } t_access;

    typedef struct packed {
        logic [1:0] hit_level;
        logic       l1_dirty_evicted;
        logic       l2_evicted_to_victim;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/two_level_lru_cache_with_victim.sv */
// two_level_lru_cache_with_victim: inclusive L1/L2 tag controller with victim cache
// sequencer over row buffers with one shared way-scan unit; depends on tlc_pkg
// tag stores are row-wide memories (one set per word), victim lines are flops
// the way-scan unit checks one way per cycle, so an access takes longer the more ways
// it scans; an L1 hit is the shortest path, a full miss with snoop and write-back the longest
// throughput: one access at a time, busy stays high until the access is finished
// the result shows on o_done for one cycle after the access; it cannot be stalled
// reset: a clearing pass over all sets of the tag memories runs with busy high
`timescale 1ns / 1ps
`default_nettype none

module two_level_lru_cache_with_victim (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tlc_pkg::t_access i_item,
    output logic                  o_done,
    output tlc_pkg::t_result      o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [3:0]       i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CAP, S_SCAN, S_SW, S_SWC, S_F1, S_F2, S_F3, S_FB,
        S_SN, S_SN2, S_VV, S_FB2, S_FL1, S_FL2, S_WB, S_WB2, S_FIN
    } t_state;

    typedef enum logic [1:0] {SEL_L1, SEL_L2, SEL_VIC} t_sel;

    // configuration
    logic [3:0] r_block_bits;
    logic [2:0] r_l1_set_bits;
    logic [1:0] r_l1_way_bits;
    logic [3:0] r_l2_set_bits;
    logic [1:0] r_l2_way_bits;
    logic       r_write_alloc;
    logic       r_victim_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bits  <= 4'd4;
            r_l1_set_bits <= 3'd6;
            r_l1_way_bits <= 2'd1;
            r_l2_set_bits <= 4'd8;
            r_l2_way_bits <= 2'd2;
            r_write_alloc <= 1'b1;
            r_victim_en   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlc_pkg::CFG_BLOCK_BITS:  r_block_bits  <= i_cfg_data;
                tlc_pkg::CFG_L1_SET_BITS: r_l1_set_bits <= i_cfg_data[2:0];
                tlc_pkg::CFG_L1_WAY_BITS: r_l1_way_bits <= i_cfg_data[1:0];
                tlc_pkg::CFG_L2_SET_BITS: r_l2_set_bits <= i_cfg_data;
                tlc_pkg::CFG_L2_WAY_BITS: r_l2_way_bits <= i_cfg_data[1:0];
                tlc_pkg::CFG_WRITE_ALLOC: r_write_alloc <= i_cfg_data[0];
                tlc_pkg::CFG_VICTIM_EN:   r_victim_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [5:0] set1(logic [31:0] blk, logic [2:0] bits);
        logic [2:0] eff;
        eff = (bits > 3'd6) ? 3'd6 : bits;
        return blk[5:0] & 6'((7'd1 << eff) - 7'd1);
    endfunction

    function automatic logic [7:0] set2(logic [31:0] blk, logic [3:0] bits);
        logic [3:0] eff;
        eff = (bits > 4'd8) ? 4'd8 : bits;
        return blk[7:0] & 8'((9'd1 << eff) - 9'd1);
    endfunction

    function automatic tlc_pkg::t_l1_row touch_l1(tlc_pkg::t_l1_row row, logic [1:0] w,
                                                  logic [1:0] last);
        tlc_pkg::t_l1_row res;
        logic [1:0]       r;
        res = row;
        r   = row[w].rank;
        for (int i = 0; i < tlc_pkg::L1_WAYS; i++) begin
            if (2'(i) <= last && row[i].rank < r) res[i].rank = row[i].rank + 2'd1;
        end
        res[w].rank = '0;
        return res;
    endfunction

    function automatic tlc_pkg::t_l2_row touch_l2(tlc_pkg::t_l2_row row, logic [2:0] w,
                                                  logic [2:0] last);
        tlc_pkg::t_l2_row res;
        logic [2:0]       r;
        res = row;
        r   = row[w].rank;
        for (int i = 0; i < tlc_pkg::L2_WAYS; i++) begin
            if (3'(i) <= last && row[i].rank < r) res[i].rank = row[i].rank + 3'd1;
        end
        res[w].rank = '0;
        return res;
    endfunction

    function automatic tlc_pkg::t_vc_row touch_vc(tlc_pkg::t_vc_row row, logic [1:0] w);
        tlc_pkg::t_vc_row res;
        logic [1:0]       r;
        res = row;
        r   = row[w].rank;
        for (int i = 0; i < tlc_pkg::VIC_ENTRIES; i++) begin
            if (row[i].rank < r) res[i].rank = row[i].rank + 2'd1;
        end
        res[w].rank = '0;
        return res;
    endfunction

    function automatic tlc_pkg::t_l1_row reset_l1_row();
        tlc_pkg::t_l1_row res;
        for (int i = 0; i < tlc_pkg::L1_WAYS; i++) begin
            res[i] = '{valid: 1'b0, dirty: 1'b0, rank: 2'(i), blk: '0};
        end
        return res;
    endfunction

    function automatic tlc_pkg::t_l2_row reset_l2_row();
        tlc_pkg::t_l2_row res;
        for (int i = 0; i < tlc_pkg::L2_WAYS; i++) begin
            res[i] = '{valid: 1'b0, dirty: 1'b0, rank: 3'(i), blk: '0};
        end
        return res;
    endfunction

    t_state           r_state;
    t_state           r_ret;
    t_sel             r_scan_sel;
    logic [7:0]       r_clr;
    logic [31:0]      r_blk;
    logic             r_wr;
    logic             r_alloc;
    logic [5:0]       r_s1;
    logic [5:0]       r_i1;
    logic [7:0]       r_i2;
    tlc_pkg::t_l1_row r_b1;
    tlc_pkg::t_l2_row r_b2;
    tlc_pkg::t_vc_row r_vc;
    logic             r_sw_l2;
    logic [7:0]       r_sw_idx;
    logic [31:0]      r_key;
    logic [2:0]       r_w;
    logic             r_fnd;
    logic [2:0]       r_fw;
    logic             r_inv;
    logic [2:0]       r_iw;
    logic [2:0]       r_bw;
    logic [2:0]       r_brank;
    logic [2:0]       r_pick2;
    logic [1:0]       r_vpick;
    logic [2:0]       r_w2;
    logic             r_slot_v;
    logic [1:0]       r_slot;
    logic             r_d;
    logic [31:0]      r_ev;
    logic             r_evd;
    logic [31:0]      r_ebk;
    logic [1:0]       r_lvl;
    logic             r_l1f;
    logic             r_vf;
    logic             r_done;
    tlc_pkg::t_result r_res;

    // memories
    tlc_pkg::t_l1_row mem1 [tlc_pkg::L1_SETS];
    tlc_pkg::t_l2_row mem2 [tlc_pkg::L2_SETS];
    tlc_pkg::t_l1_row r_q1;
    tlc_pkg::t_l2_row r_q2;

    logic             accept;
    logic [31:0]      in_blk;
    logic             sw_miss1;
    logic             sw_miss2;
    logic             we1;
    logic             we2;
    logic             re1;
    logic             re2;
    logic [5:0]       waddr1;
    logic [7:0]       waddr2;
    logic [5:0]       raddr1;
    logic [7:0]       raddr2;
    tlc_pkg::t_l1_row wdata1;
    tlc_pkg::t_l2_row wdata2;

    assign accept   = start && r_state == S_IDLE;
    assign in_blk   = i_item.byte_address >> r_block_bits;
    assign sw_miss1 = r_state == S_SW && !r_sw_l2 && r_sw_idx[5:0] != r_i1;
    assign sw_miss2 = r_state == S_SW && r_sw_l2 && r_sw_idx != r_i2;

    always_comb begin
        we1    = (r_state == S_CLEAR && r_clr < 8'(tlc_pkg::L1_SETS)) || sw_miss1 ||
                 r_state == S_FIN;
        we2    = r_state == S_CLEAR || sw_miss2 || r_state == S_FIN;
        waddr1 = (r_state == S_CLEAR) ? r_clr[5:0] : r_i1;
        waddr2 = (r_state == S_CLEAR) ? r_clr : r_i2;
        wdata1 = (r_state == S_CLEAR) ? reset_l1_row() : r_b1;
        wdata2 = (r_state == S_CLEAR) ? reset_l2_row() : r_b2;
        re1    = accept || sw_miss1;
        re2    = accept || sw_miss2;
        raddr1 = accept ? set1(in_blk, r_l1_set_bits) : r_sw_idx[5:0];
        raddr2 = accept ? set2(in_blk, r_l2_set_bits) : r_sw_idx;
    end

    always_ff @(posedge i_clk) begin
        if (we1) mem1[waddr1] <= wdata1;
        if (re1) r_q1 <= mem1[raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (we2) mem2[waddr2] <= wdata2;
        if (re2) r_q2 <= mem2[raddr2];
    end

    // shared way-scan unit: one line per cycle
    logic             sv;
    logic [2:0]       srank;
    logic [31:0]      sblk;
    logic [2:0]       scan_last;
    logic [2:0]       last1;
    logic [2:0]       last2;
    logic [1:0]       eff1;
    logic             shit;
    logic [2:0]       pick;
    logic [1:0]       vidx;
    tlc_pkg::t_l1_row touch1_fw;
    tlc_pkg::t_l1_row touch1_pick;
    tlc_pkg::t_l2_row touch2_fw;
    tlc_pkg::t_l2_row touch2_w2;
    tlc_pkg::t_vc_row vc_ins;
    tlc_pkg::t_vc_row touch_v;
    tlc_pkg::t_l1_row upd1_hit;
    tlc_pkg::t_l1_row upd1_fill;
    tlc_pkg::t_l2_row upd2_dirty;
    tlc_pkg::t_l2_row upd2_fill;

    assign eff1  = (r_l1_way_bits > 2'd2) ? 2'd2 : r_l1_way_bits;
    assign last1 = (3'd1 << eff1) - 3'd1;
    assign last2 = 3'((4'd1 << r_l2_way_bits) - 4'd1);
    assign pick  = r_inv ? r_iw : r_bw;
    assign vidx  = r_slot_v ? r_slot : r_vpick;

    always_comb begin
        unique case (r_scan_sel)
            SEL_L1: begin
                sv        = r_b1[r_w[1:0]].valid;
                srank     = {1'b0, r_b1[r_w[1:0]].rank};
                sblk      = r_b1[r_w[1:0]].blk;
                scan_last = last1;
            end
            SEL_L2: begin
                sv        = r_b2[r_w].valid;
                srank     = r_b2[r_w].rank;
                sblk      = r_b2[r_w].blk;
                scan_last = last2;
            end
            SEL_VIC: begin
                sv        = r_vc[r_w[1:0]].valid;
                srank     = {1'b0, r_vc[r_w[1:0]].rank};
                sblk      = r_vc[r_w[1:0]].blk;
                scan_last = 3'(tlc_pkg::VIC_ENTRIES - 1);
            end
            default: begin
                sv        = 1'b0;
                srank     = '0;
                sblk      = '0;
                scan_last = '0;
            end
        endcase
        shit = sv && sblk == r_key;
    end

    always_comb begin
        touch1_fw   = touch_l1(r_b1, r_fw[1:0], last1[1:0]);
        touch1_pick = touch_l1(r_b1, pick[1:0], last1[1:0]);
        touch2_fw   = touch_l2(r_b2, r_fw, last2);
        touch2_w2   = touch_l2(r_b2, r_w2, last2);
        vc_ins      = r_vc;
        vc_ins[vidx].valid = 1'b1;
        vc_ins[vidx].dirty = r_evd;
        vc_ins[vidx].blk   = r_ev;
        touch_v     = touch_vc(vc_ins, vidx);
        // updated rows for hit, fill and write-back
        upd1_hit = touch1_fw;
        if (r_wr) upd1_hit[r_fw[1:0]].dirty = 1'b1;
        upd1_fill = touch1_pick;
        upd1_fill[pick[1:0]].valid = 1'b1;
        upd1_fill[pick[1:0]].blk   = r_blk;
        upd1_fill[pick[1:0]].dirty = r_b2[r_w2].dirty || r_wr;
        upd2_dirty = touch2_fw;
        upd2_dirty[r_fw].dirty = 1'b1;
        upd2_fill = touch2_w2;
        upd2_fill[r_w2].valid = 1'b1;
        upd2_fill[r_w2].dirty = r_d;
        upd2_fill[r_w2].blk   = r_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < tlc_pkg::VIC_ENTRIES; i++) begin
                r_vc[i] <= '{valid: 1'b0, dirty: 1'b0, rank: 2'(i), blk: '0};
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == 8'(tlc_pkg::L2_SETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_blk    <= in_blk;
                        r_wr     <= i_item.is_write;
                        r_alloc  <= r_write_alloc || !i_item.is_write;
                        r_s1     <= set1(in_blk, r_l1_set_bits);
                        r_i1     <= set1(in_blk, r_l1_set_bits);
                        r_i2     <= set2(in_blk, r_l2_set_bits);
                        r_l1f    <= 1'b0;
                        r_vf     <= 1'b0;
                        r_slot_v <= 1'b0;
                        r_state  <= S_CAP;
                    end
                end
                S_CAP: begin
                    r_b1       <= r_q1;
                    r_b2       <= r_q2;
                    r_scan_sel <= SEL_L1;
                    r_key      <= r_blk;
                    r_w        <= '0;
                    r_ret      <= S_F1;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_w == '0) begin
                        r_fnd   <= shit;
                        r_fw    <= '0;
                        r_inv   <= !sv;
                        r_iw    <= '0;
                        r_bw    <= '0;
                        r_brank <= srank;
                    end else begin
                        if (!r_fnd && shit) begin
                            r_fnd <= 1'b1;
                            r_fw  <= r_w;
                        end
                        if (!r_inv && !sv) begin
                            r_inv <= 1'b1;
                            r_iw  <= r_w;
                        end
                        if (srank > r_brank) begin
                            r_bw    <= r_w;
                            r_brank <= srank;
                        end
                    end
                    if (r_w == scan_last) r_state <= r_ret;
                    else r_w <= r_w + 3'd1;
                end
                S_SW: begin
                    if (r_sw_l2 ? (r_sw_idx == r_i2) : (r_sw_idx[5:0] == r_i1)) begin
                        r_state <= r_ret;
                    end else begin
                        if (r_sw_l2) r_i2 <= r_sw_idx;
                        else r_i1 <= r_sw_idx[5:0];
                        r_state <= S_SWC;
                    end
                end
                S_SWC: begin
                    if (r_sw_l2) r_b2 <= r_q2;
                    else r_b1 <= r_q1;
                    r_state <= r_ret;
                end
                S_F1: begin
                    if (r_fnd) begin
                        r_b1    <= upd1_hit;
                        r_lvl   <= tlc_pkg::LVL_L1;
                        r_state <= S_FIN;
                    end else begin
                        r_scan_sel <= SEL_L2;
                        r_w        <= '0;
                        r_ret      <= S_F2;
                        r_state    <= S_SCAN;
                    end
                end
                S_F2: begin
                    r_pick2 <= pick;
                    if (r_fnd) begin
                        r_lvl <= tlc_pkg::LVL_L2;
                        if (!r_alloc) begin
                            r_b2    <= upd2_dirty;
                            r_state <= S_FIN;
                        end else begin
                            r_b2    <= touch2_fw;
                            r_w2    <= r_fw;
                            r_state <= S_FL1;
                        end
                    end else if (r_victim_en) begin
                        r_scan_sel <= SEL_VIC;
                        r_w        <= '0;
                        r_ret      <= S_F3;
                        r_state    <= S_SCAN;
                    end else begin
                        r_lvl   <= tlc_pkg::LVL_MEM;
                        r_d     <= 1'b0;
                        r_state <= r_alloc ? S_FB : S_FIN;
                    end
                end
                S_F3: begin
                    r_vpick <= pick[1:0];
                    if (r_fnd) begin
                        r_lvl <= tlc_pkg::LVL_VIC;
                        if (!r_alloc) begin
                            r_vc[r_fw[1:0]].dirty <= 1'b1;
                            r_state               <= S_FIN;
                        end else begin
                            r_d              <= r_vc[r_fw[1:0]].dirty;
                            r_vc[r_fw[1:0]]  <= '{valid: 1'b0, dirty: 1'b0,
                                                  rank: r_vc[r_fw[1:0]].rank,
                                                  blk: r_vc[r_fw[1:0]].blk};
                            r_slot_v         <= 1'b1;
                            r_slot           <= r_fw[1:0];
                            r_state          <= S_FB;
                        end
                    end else begin
                        r_lvl   <= tlc_pkg::LVL_MEM;
                        r_d     <= 1'b0;
                        r_state <= r_alloc ? S_FB : S_FIN;
                    end
                end
                S_FB: begin
                    r_w2 <= r_pick2;
                    if (r_b2[r_pick2].valid) begin
                        // evicted L2 block: drop its L1 copy first
                        r_ev     <= r_b2[r_pick2].blk;
                        r_evd    <= r_b2[r_pick2].dirty;
                        r_sw_l2  <= 1'b0;
                        r_sw_idx <= {2'b00, set1(r_b2[r_pick2].blk, r_l1_set_bits)};
                        r_ret    <= S_SN;
                        r_state  <= S_SW;
                    end else begin
                        r_state <= S_FB2;
                    end
                end
                S_SN: begin
                    r_scan_sel <= SEL_L1;
                    r_key      <= r_ev;
                    r_w        <= '0;
                    r_ret      <= S_SN2;
                    r_state    <= S_SCAN;
                end
                S_SN2: begin
                    if (r_fnd) begin
                        r_b1[r_fw[1:0]].valid <= 1'b0;
                        if (r_b1[r_fw[1:0]].dirty) r_evd <= 1'b1;
                    end
                    r_state <= S_VV;
                end
                S_VV: begin
                    if (r_victim_en) begin
                        r_vc <= touch_v;
                        r_vf <= 1'b1;
                    end
                    r_state <= S_FB2;
                end
                S_FB2: begin
                    r_b2     <= upd2_fill;
                    r_sw_l2  <= 1'b0;
                    r_sw_idx <= {2'b00, r_s1};
                    r_ret    <= S_FL1;
                    r_state  <= S_SW;
                end
                S_FL1: begin
                    r_scan_sel <= SEL_L1;
                    r_key      <= r_blk;
                    r_w        <= '0;
                    r_ret      <= S_FL2;
                    r_state    <= S_SCAN;
                end
                S_FL2: begin
                    r_b1             <= upd1_fill;
                    r_b2[r_w2].dirty <= 1'b0;
                    if (r_b1[pick[1:0]].valid && r_b1[pick[1:0]].dirty) begin
                        // dirty L1 victim writes back into its own L2 set
                        r_l1f    <= 1'b1;
                        r_ebk    <= r_b1[pick[1:0]].blk;
                        r_sw_l2  <= 1'b1;
                        r_sw_idx <= set2(r_b1[pick[1:0]].blk, r_l2_set_bits);
                        r_ret    <= S_WB;
                        r_state  <= S_SW;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_WB: begin
                    r_scan_sel <= SEL_L2;
                    r_key      <= r_ebk;
                    r_w        <= '0;
                    r_ret      <= S_WB2;
                    r_state    <= S_SCAN;
                end
                S_WB2: begin
                    if (r_fnd) r_b2 <= upd2_dirty;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_res   <= '{hit_level: r_lvl, l1_dirty_evicted: r_l1f,
                                 l2_evicted_to_victim: r_vf};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result transfer without a finished access");

    a_l1_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.hit_level == tlc_pkg::LVL_L1) |->
        (!o_result.l1_dirty_evicted && !o_result.l2_evicted_to_victim))
        else $error("L1 hit reported an eviction");

    a_victim_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.l2_evicted_to_victim) |-> r_victim_en)
        else $error("victim fill while victim cache disabled");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_w <= scan_last))
        else $error("way scan past last way in use");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (busy && !o_done))
        else $error("access possible during clearing pass");

endmodule

`default_nettype wire
